/* hw/rtl/rsst_pkg.sv */
// range-sum segment tree: shared constants, request kinds and sequencer states
// no dependencies

package rsst_pkg;

	localparam int LEAVES = 1024;
	localparam int DATA_W = 32;
	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = $clog2(NODES);
	localparam int IDX_W  = NODE_W + 1;
	localparam int POS_W  = $clog2(LEAVES);
	localparam int SIZE_W = POS_W + 1;

	localparam logic KIND_SET   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(LEAVES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET,
		ST_UP,
		ST_QA,
		ST_QB,
		ST_DONE
	} rsst_state_t;

endpackage

/* hw/rtl/rsst_if.sv */
// request and result channels of the range-sum segment tree
// depends on rsst_pkg

interface rsst_req_if import rsst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [POS_W-1:0]         position;
	logic [SIZE_W-1:0]        range_end;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, kind, position, range_end, value, input ready);
	modport sink   (input valid, kind, position, range_end, value, output ready);
endinterface

interface rsst_rsp_if import rsst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

/* hw/rtl/range_sum_segment_tree.sv */
// range-sum segment tree top level: sequencer around one node ram
// depends on rsst_pkg, rsst_if, rsst_ram
//
// usage
//   req carries set requests (kind 0: write value at position) and query
//   requests (kind 1: wrapped sum over [position, range_end)). rsp gives one
//   range_sum per query; sets give none. cfg_we/cfg_wdata write size_in_use;
//   the user must write it only while the block is idle; the block does not enforce this.
//   one request at a time: req.ready is high only between requests.
//   a set writes the leaf and then walks up the tree, at each level a ram
//   read of the sibling and a write of the parent. a query reads up to two
//   nodes per level walked, in ST_QA and ST_QB, since the ram has a single
//   read port. a set beyond the size in use is dropped.
//   results sit in an output register; the next request is taken while a
//   result waits. a query that finishes while the register is still full
//   holds until rsp.ready.
//   after reset the node ram is cleared, one entry a cycle, all 2048 entries,
//   with req.ready low; size_in_use resets to 1024.

module range_sum_segment_tree import rsst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	rsst_req_if.sink          req,
	rsst_rsp_if.source        rsp
);

	rsst_state_t       state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] node_q;
	logic [DATA_W-1:0] cur_q;
	logic [IDX_W-1:0]  lo_q, hi_q;
	logic [DATA_W-1:0] acc_q;
	logic              pend_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_sum_q;

	logic [SIZE_W-1:0] n_eff;
	logic [SIZE_W-1:0] end_clamp;
	logic              accept;
	logic              out_free;
	logic [NODE_W-1:0] node_up;
	logic [DATA_W-1:0] up_sum;
	logic [DATA_W-1:0] acc_next;
	logic [IDX_W-1:0]  hi_dec;

	logic              mem_we, mem_re;
	logic [NODE_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	rsst_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NODES)
	) u_nodes (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		if (size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(LEAVES)) begin
			n_eff = SIZE_W'(LEAVES);
		end else begin
			n_eff = size_q;
		end
	end

	assign end_clamp = (req.range_end > n_eff) ? n_eff : req.range_end;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign node_up   = node_q >> 1;
	assign up_sum    = cur_q + mem_rdata;
	assign acc_next  = acc_q + (pend_q ? mem_rdata : DATA_W'(0));
	assign hi_dec    = hi_q - IDX_W'(hi_q[0]);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = cur_q;
		mem_re    = 1'b0;
		mem_raddr = node_q ^ NODE_W'(1);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_QUERY) begin
						state_d = ST_QA;
					end else if ({1'b0, req.position} < n_eff) begin
						state_d = ST_SET;
					end
				end
			end
			ST_SET: begin
				mem_we = 1'b1;
				if (node_q > NODE_W'(1)) begin
					mem_re  = 1'b1;
					state_d = ST_UP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UP: begin
				mem_we    = 1'b1;
				mem_waddr = node_up;
				mem_wdata = up_sum;
				mem_raddr = node_up ^ NODE_W'(1);
				if (node_up > NODE_W'(1)) begin
					mem_re = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_QA: begin
				mem_raddr = lo_q[NODE_W-1:0];
				if (lo_q < hi_q) begin
					mem_re  = lo_q[0];
					state_d = ST_QB;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_QB: begin
				mem_raddr = hi_dec[NODE_W-1:0];
				mem_re    = hi_q[0];
				state_d   = ST_QA;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SIZE_RESET;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_QA) begin
				pend_q <= (lo_q < hi_q) && lo_q[0];
			end else if (state_q == ST_QB) begin
				pend_q <= hi_q[0];
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				node_q <= NODE_W'(n_eff) + NODE_W'(req.position);
				cur_q  <= req.value;
				lo_q   <= IDX_W'(n_eff) + IDX_W'(req.position);
				hi_q   <= IDX_W'(n_eff) + IDX_W'(end_clamp);
				acc_q  <= '0;
			end
			ST_UP: begin
				node_q <= node_up;
				cur_q  <= up_sum;
			end
			ST_QA: begin
				acc_q <= acc_next;
				if (lo_q < hi_q && lo_q[0]) begin
					lo_q <= lo_q + IDX_W'(1);
				end
			end
			ST_QB: begin
				acc_q <= acc_next;
				lo_q  <= lo_q >> 1;
				hi_q  <= hi_dec >> 1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_sum_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;

`ifndef SYNTHESIS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("node ram read and write at the same entry");

	a_walk_above_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP) |-> (node_q > NODE_W'(1)))
		else $error("set walk past the root");

	a_query_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QB) |-> (lo_q <= hi_q && hi_q <= IDX_W'(NODES)))
		else $error("query bounds crossed");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result without a finished query");
`endif

endmodule

/* hw/rtl/rsst_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module rsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* tb/sv/range_sum_segment_tree_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for range_sum_segment_tree: sets and range queries
// checked against an in-bench mirror of the node store under several leaf counts
// depends on rsst_pkg, rsst_if and the range_sum_segment_tree rtl

module range_sum_segment_tree_tb;
	import rsst_pkg::*;

	typedef struct packed {
		logic                     kind;
		logic [POS_W-1:0]         position;
		logic [SIZE_W-1:0]        range_end;
		logic signed [DATA_W-1:0] value;
	} tree_request_t;

	localparam int SETTLE_CYCLES = 32;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	rsst_req_if req ();
	rsst_rsp_if rsp ();

	range_sum_segment_tree u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	logic [DATA_W-1:0]        node_mirror [NODES];
	logic [SIZE_W-1:0]        size_mirror;
	logic signed [DATA_W-1:0] expected_sums [$];

	int send_idle_pct;
	int recv_stall_pct;
	int rsp_hold_cycles;
	int mismatches;
	int sets_sent;
	int queries_sent;
	int sums_checked;
	int sizes_tried;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("Verification failed");
		$finish;
	end

	// mirror of the node store
	function automatic int active_leaves();
		int n;
		n = int'(size_mirror);
		if (n < 1)
			n = 1;
		if (n > LEAVES)
			n = LEAVES;
		return n;
	endfunction

	function automatic void write_leaf(int n, int pos, logic [DATA_W-1:0] v);
		int k;
		k = pos + n;
		node_mirror[k] = v;
		while (k > 1) begin
			node_mirror[k >> 1] = node_mirror[k] + node_mirror[k ^ 1];
			k = k >> 1;
		end
	endfunction

	function automatic logic [DATA_W-1:0] sum_leaves(int n, int lo, int hi);
		logic [DATA_W-1:0] acc;
		acc = '0;
		lo += n;
		hi += n;
		while (lo < hi) begin
			if (lo % 2 == 1) begin
				acc += node_mirror[lo];
				lo++;
			end
			if (hi % 2 == 1) begin
				hi--;
				acc += node_mirror[hi];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	function automatic void apply_to_mirror(tree_request_t r);
		int n;
		int pos;
		int hi;
		n   = active_leaves();
		pos = int'(r.position);
		hi  = int'(r.range_end);
		if (r.kind == KIND_SET) begin
			sets_sent++;
			if (pos < n)
				write_leaf(n, pos, r.value);
		end else begin
			queries_sent++;
			if (hi > n)
				hi = n;
			expected_sums.push_back((pos < hi) ? sum_leaves(n, pos, hi) : '0);
		end
	endfunction

	function automatic tree_request_t build_request(logic kind, int pos, int hi,
			logic [DATA_W-1:0] v);
		tree_request_t r;
		r.kind      = kind;
		r.position  = POS_W'(pos);
		r.range_end = SIZE_W'(hi);
		r.value     = v;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 32'h7FFF_FFFF;
		if (roll < 6)
			return 32'h8000_0000;
		if (roll < 8)
			return 32'hFFFF_FFFF;
		if (roll < 10)
			return '0;
		return $urandom;
	endfunction

	// mostly well-formed ranges inside the leaves in use, some stray ones
	function automatic tree_request_t random_request();
		int n;
		int roll;
		int lo;
		int hi;
		n    = active_leaves();
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEAVES - 1)
				: $urandom_range(0, n - 1);
			return build_request(KIND_SET, lo, $urandom_range(0, 2047), random_value());
		end
		if (roll < 80) begin
			lo = $urandom_range(0, n - 1);
			hi = $urandom_range(lo + 1, n);
		end else if (roll < 92) begin
			lo = $urandom_range(0, LEAVES - 1);
			hi = $urandom_range(0, 2047);
		end else begin
			lo = $urandom_range(0, n - 1);
			hi = $urandom_range(n, 2047);
		end
		return build_request(KIND_QUERY, lo, hi, $urandom);
	endfunction

	// valid is left high after acceptance so back-to-back requests never toggle it
	task automatic send_request(tree_request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.kind      <= r.kind;
		req.position  <= r.position;
		req.range_end <= r.range_end;
		req.value     <= r.value;
		do
			@(posedge clk);
		while (!req.ready);
		apply_to_mirror(r);
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		wait (expected_sums.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic write_size(int v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= SIZE_W'(v);
		@(posedge clk);
		size_mirror = SIZE_W'(v);
		cfg_we <= 1'b0;
		sizes_tried++;
	endtask

	task automatic report_mismatch(string what, logic signed [DATA_W-1:0] want,
			logic signed [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): range_sum expected %0d (0x%08h), got %0d (0x%08h)",
				what, want, want, got, got);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		logic signed [DATA_W-1:0] want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch("no query outstanding", '0, rsp.range_sum);
			end else begin
				want = expected_sums.pop_front();
				if (rsp.range_sum !== want)
					report_mismatch("query result", want, rsp.range_sum);
				sums_checked++;
			end
		end
	end

	// result receiver: random stalls plus a counted hold-off
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				rsp_hold_cycles--;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic test_cleared_store_and_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		settle();
		send_request(build_request(KIND_QUERY, 0, LEAVES, '0));
		send_request(build_request(KIND_SET, 0, 0, 32'h7FFF_FFFF));
		send_request(build_request(KIND_SET, 1023, 2047, 32'h8000_0000));
		send_request(build_request(KIND_SET, 1, 0, 32'hFFFF_FFFF));
		send_request(build_request(KIND_SET, 512, 0, 32'h0000_0001));
		send_request(build_request(KIND_SET, 2, 0, 32'h7FFF_FFFF));
		send_request(build_request(KIND_QUERY, 0, LEAVES, '0));
		send_request(build_request(KIND_QUERY, 0, 2047, '0));
		send_request(build_request(KIND_QUERY, 1023, LEAVES, 32'hFFFF_FFFF));
		send_request(build_request(KIND_QUERY, 0, 3, '0));
		send_request(build_request(KIND_QUERY, 5, 5, '0));
		send_request(build_request(KIND_QUERY, 10, 3, '0));
		send_request(build_request(KIND_QUERY, 1023, 2047, '0));
		send_request(build_request(KIND_QUERY, 0, 0, '0));
		send_request(build_request(KIND_SET, 1023, 0, '0));
		send_request(build_request(KIND_QUERY, 511, 513, '0));
		send_request(build_request(KIND_SET, 700, 0, 32'h5555_5555));
		send_request(build_request(KIND_SET, 701, 0, 32'hAAAA_AAAA));
		send_request(build_request(KIND_QUERY, 700, 702, '0));
		send_request(build_request(KIND_QUERY, 0, LEAVES, '0));
	endtask

	// leaf counts including zero and out-of-range values that saturate
	task automatic test_leaf_counts();
		int counts [11];
		int n;
		counts = '{1, 0, 2, 3, 7, 2047, 1025, 513, 100, 16, 1024};
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		foreach (counts[i]) begin
			write_size(counts[i]);
			n = active_leaves();
			send_request(build_request(KIND_SET, n - 1, 0, random_value()));
			if (n < LEAVES) begin
				send_request(build_request(KIND_SET, n, 0, random_value()));
				send_request(build_request(KIND_SET, LEAVES - 1, 0, random_value()));
			end
			send_request(build_request(KIND_QUERY, 0, 2047, '0));
			send_request(build_request(KIND_QUERY, 0, n, '0));
			send_request(build_request(KIND_QUERY, n - 1, n, '0));
			repeat (22)
				send_request(random_request());
		end
	endtask

	task automatic test_random_traffic();
		int idle_pcts [4];
		int stall_pcts [4];
		int counts [4];
		idle_pcts  = '{0, 52, 0, 20};
		stall_pcts = '{0, 0, 52, 20};
		counts     = '{1024, 37, 1024, 600};
		for (int m = 0; m < 4; m++) begin
			write_size(counts[m]);
			send_idle_pct  = idle_pcts[m];
			recv_stall_pct = stall_pcts[m];
			repeat (280)
				send_request(random_request());
		end
	endtask

	// results held off long enough that the block stops taking requests
	task automatic test_result_hold_off();
		int n;
		write_size(LEAVES);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		n = active_leaves();
		rsp_hold_cycles = 400;
		repeat (50)
			send_request(build_request(KIND_QUERY, $urandom_range(0, n / 2),
				$urandom_range(n / 2 + 1, n), '0));
		repeat (10)
			send_request(random_request());
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req.valid       <= 1'b0;
		req.kind        <= KIND_SET;
		req.position    <= '0;
		req.range_end   <= '0;
		req.value       <= '0;
		size_mirror      = SIZE_RESET;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		rsp_hold_cycles  = 0;
		mismatches       = 0;
		sets_sent        = 0;
		queries_sent     = 0;
		sums_checked     = 0;
		sizes_tried      = 0;
		foreach (node_mirror[i])
			node_mirror[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_cleared_store_and_extremes();
		test_leaf_counts();
		test_random_traffic();
		test_result_hold_off();

		settle();
		$display("covered %0d requests: %0d sets and %0d queries, %0d sums checked",
			sets_sent + queries_sent, sets_sent, queries_sent, sums_checked);
		$display("over %0d leaf count writes, with idle, stall and long hold-off phases",
			sizes_tried);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
